FILE: rtl/core/pbds_pkg.sv
// Shared constants and types for the packet buffer drop scheduler.
package pbds_pkg;

	localparam int DEF_BUF_DEPTH  = 64;
	localparam int DEF_TIME_WIDTH = 32;

	localparam int CFG_W   = 7;
	localparam int FIELD_W = 32;

	localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

	// Per-cycle command broadcast along the row of finish-time cells.
	typedef struct packed {
		logic pop;   // retire the oldest entry, every cell takes its upper neighbor
		logic push;  // append a new finish time at the fill position
	} cell_ctrl_t;

endpackage

FILE: rtl/core/packet_buffer_drop_scheduler.sv
// Top level of the packet buffer drop scheduler: control, row of cells, result register.
//
// Usage: each input beat on the s_ channel is one packet (arrival and process time).
// Arrival times are expected to be nondecreasing. For every packet exactly one result
// beat leaves on the m_ channel: a drop flag in m_tuser and the service start time in
// m_tdata (zero when dropped). The cfg channel writes buffer_size, the number of packets
// held at once including the one in service; it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Finish times live in a row of BUF_DEPTH cells, oldest in cell 0. Retiring a packet
// shifts the whole row down by one cell at once, so a packet passes through an accept
// step, a retirement step for each retired finish time, and a decision step that
// appends the new finish time and loads the result register, which raises result
// valid. Averaged over a stream each packet is retired at most once.
// The result register holds its beat while m_tready is low; the decision cycle waits
// for the register to free up, and no new packet is taken until it has been loaded.
// Reset (arst_n low) empties the buffer and sets buffer_size to 64. Cell contents are
// not cleared; a cell is only read once it holds a packet.
module packet_buffer_drop_scheduler #(
	parameter int BUF_DEPTH  = pbds_pkg::DEF_BUF_DEPTH,
	parameter int TIME_WIDTH = pbds_pkg::DEF_TIME_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] arrival, [63:32] service duration
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] service start
	output logic        m_tuser,   // [0] dropped
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data   // [6:0] buffer_size
);

	localparam int CW = $clog2(BUF_DEPTH + 1);
	localparam int KW = (CW > pbds_pkg::CFG_W) ? CW : pbds_pkg::CFG_W;
	localparam int XW = (TIME_WIDTH > pbds_pkg::FIELD_W) ? TIME_WIDTH : pbds_pkg::FIELD_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                      state_q;
	logic [CW-1:0]             count_q;
	logic [TIME_WIDTH-1:0]     tail_q;
	logic [TIME_WIDTH-1:0]     arr_q;
	logic [TIME_WIDTH-1:0]     proc_q;
	logic [pbds_pkg::CFG_W-1:0] size_q;
	logic                      m_tvalid_q;
	logic [31:0]               m_tdata_q;
	logic                      m_tuser_q;

	logic [TIME_WIDTH-1:0] cell_val [BUF_DEPTH];
	pbds_pkg::cell_ctrl_t  ctrl;

	logic                  in_acc;
	logic                  out_free;
	logic                  can_pop;
	logic                  decide;
	logic                  full;
	logic [KW-1:0]         size_x;
	logic [KW-1:0]         cap;
	logic [XW-1:0]         arr_x;
	logic [XW-1:0]         proc_x;
	logic [XW-1:0]         start_x;
	logic [TIME_WIDTH-1:0] start_t;
	logic [TIME_WIDTH:0]   sum;
	logic [TIME_WIDTH-1:0] finish;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	assign arr_x  = XW'(s_tdata[31:0]);
	assign proc_x = XW'(s_tdata[63:32]);

	// A zero size acts as one; sizes beyond the row length are clipped to it.
	assign size_x = KW'(size_q);
	always_comb begin
		if (size_q == '0) begin
			cap = KW'(1);
		end else if (size_x > KW'(BUF_DEPTH)) begin
			cap = KW'(BUF_DEPTH);
		end else begin
			cap = size_x;
		end
	end

	// Retire the oldest finish time while it is at or before the arrival.
	assign can_pop = (state_q == ST_RUN) && (count_q != '0) && (cell_val[0] <= arr_q);
	assign decide  = (state_q == ST_RUN) && !can_pop && out_free;
	assign full    = KW'(count_q) >= cap;

	// An empty buffer starts service at arrival, otherwise at the newest finish time.
	assign start_t = (count_q == '0) ? arr_q : tail_q;
	assign start_x = XW'(start_t);
	assign sum     = {1'b0, start_t} + {1'b0, proc_q};
	assign finish  = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];

	assign ctrl.pop  = can_pop;
	assign ctrl.push = decide && !full;

	for (genvar i = 0; i < BUF_DEPTH; i++) begin : g_cell
		logic [TIME_WIDTH-1:0] upper;
		if (i == BUF_DEPTH - 1) begin : g_top
			assign upper = '0;
		end else begin : g_mid
			assign upper = cell_val[i+1];
		end
		pbds_cell #(
			.IDX        (i),
			.CW         (CW),
			.TIME_WIDTH (TIME_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.fill      (count_q),
			.upper_val (upper),
			.push_val  (finish),
			.val       (cell_val[i])
		);
	end

	// Packet operands are held for the whole run of the packet.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			arr_q  <= arr_x[TIME_WIDTH-1:0];
			proc_q <= proc_x[TIME_WIDTH-1:0];
		end
		if (ctrl.push) begin
			tail_q <= finish;
		end
		if (decide) begin
			m_tuser_q <= full;
			m_tdata_q <= full ? 32'd0 : start_x[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			size_q     <= pbds_pkg::CFG_SIZE_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (decide) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ctrl.pop) begin
				count_q <= count_q - CW'(1);
			end else if (ctrl.push) begin
				count_q <= count_q + CW'(1);
			end
			if (decide) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// The buffer never holds more packets than it has cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		KW'(count_q) <= KW'(BUF_DEPTH))
		else $error("held count exceeds buffer depth");

	// A dropped packet always reports a zero start time.
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 32'd0))
		else $error("dropped packet with nonzero start time");

	// Retiring a finish time lowers the held count by exactly one.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> (count_q == $past(count_q) - CW'(1)))
		else $error("retire did not decrement held count");

	// Nothing new is taken until the current packet has produced its result.
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("second packet taken during a run");

endmodule

FILE: rtl/core/pbds_cell.sv
// One finish-time cell of the shifting queue.
module pbds_cell #(
	parameter int IDX        = 0,
	parameter int CW         = 7,
	parameter int TIME_WIDTH = pbds_pkg::DEF_TIME_WIDTH
) (
	input  logic                   clk,
	input  pbds_pkg::cell_ctrl_t   ctrl,
	input  logic [CW-1:0]          fill,
	input  logic [TIME_WIDTH-1:0]  upper_val,
	input  logic [TIME_WIDTH-1:0]  push_val,
	output logic [TIME_WIDTH-1:0]  val
);

	logic [TIME_WIDTH-1:0] val_q;

	// The cell sitting at the fill position takes the pushed value.
	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			val_q <= upper_val;
		end else if (ctrl.push && (fill == CW'(IDX))) begin
			val_q <= push_val;
		end
	end

	assign val = val_q;

endmodule

FILE: tb/pbds_checker.sv
// Checker for the packet buffer drop scheduler: predicts every result beat and compares it.
module pbds_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [63:0]                s_tdata,   // [31:0] arrival, [63:32] service duration
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [31:0]                m_tdata,   // [31:0] service start
	input  logic                       m_tuser,   // [0] dropped
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [pbds_pkg::CFG_W-1:0] cfg_data,  // [6:0] buffer_size
	output int                         fail_count,
	output int                         pending,
	output int                         results_seen,
	output int                         drops_seen
);
	localparam int DEPTH = pbds_pkg::DEF_BUF_DEPTH;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int OCC_W = IDX_W + 1;

	typedef struct packed {
		logic        dropped;
		logic [31:0] start_val;
	} grant_t;

	logic [31:0]                finish_mem [DEPTH];
	logic [IDX_W-1:0]           oldest = '0;
	logic [IDX_W:0]             occupancy = '0;
	logic [pbds_pkg::CFG_W-1:0] size_reg = pbds_pkg::CFG_SIZE_RESET;
	grant_t                     grant_q [$];

	// A size of zero acts as one, and anything above the ring depth acts as the depth.
	function automatic logic [IDX_W:0] capacity_of(input logic [pbds_pkg::CFG_W-1:0] sz);
		if (sz == 0)
			return OCC_W'(1);
		if (sz > DEPTH)
			return OCC_W'(DEPTH);
		return sz[IDX_W:0];
	endfunction

	task automatic admit_packet(input logic [31:0] arrival, input logic [31:0] service);
		logic [31:0] begin_at;
		logic [32:0] sum;
		grant_t      g;
		// Retire finished packets, oldest first, stopping at the first one still busy.
		while (occupancy != 0 && finish_mem[oldest] <= arrival) begin
			oldest = oldest + 1'b1;
			occupancy = occupancy - 1'b1;
		end
		if (occupancy >= capacity_of(size_reg)) begin
			g.dropped = 1'b1;
			g.start_val = '0;
		end else begin
			if (occupancy == 0)
				begin_at = arrival;
			else
				begin_at = finish_mem[IDX_W'(oldest + occupancy - 1'b1)];
			sum = {1'b0, begin_at} + {1'b0, service};
			finish_mem[IDX_W'(oldest + occupancy)] = sum[32] ? '1 : sum[31:0];
			occupancy = occupancy + 1'b1;
			g.dropped = 1'b0;
			g.start_val = begin_at;
		end
		grant_q.insert(grant_q.size(), g);
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			oldest = '0;
			occupancy = '0;
			size_reg = pbds_pkg::CFG_SIZE_RESET;
			grant_q.delete();
			fail_count = 0;
			results_seen = 0;
			drops_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (m_tuser)
					drops_seen++;
				if (grant_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result beat: expected none, actual dropped %0b start %h",
						$time, m_tuser, m_tdata);
				end else begin
					want = grant_q.pop_front();
					if (m_tuser !== want.dropped) begin
						fail_count++;
						$display("%0t: dropped expected %0b actual %0b",
							$time, want.dropped, m_tuser);
					end
					if (m_tdata !== want.start_val) begin
						fail_count++;
						$display("%0t: start expected %h actual %h",
							$time, want.start_val, m_tdata);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				size_reg = cfg_data;
			if (s_tvalid && s_tready)
				admit_packet(s_tdata[31:0], s_tdata[63:32]);
		end
		pending = grant_q.size();
	end

endmodule

FILE: tb/testbench.sv
// Top of the packet buffer drop scheduler testbench: stimulus, back pressure and verdict.
module testbench;
	localparam int SZ_W = pbds_pkg::CFG_W;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [63:0]      s_tdata;    // [31:0] arrival, [63:32] service duration
	logic             m_tvalid;
	logic             m_tready;
	logic [31:0]      m_tdata;    // [31:0] service start
	logic             m_tuser;    // [0] dropped
	logic             cfg_valid;
	logic             cfg_ready;
	logic [SZ_W-1:0]  cfg_data;   // [6:0] buffer_size

	int fail_count;
	int pending;
	int results_seen;
	int drops_seen;
	int packets_sent;
	int settings_used;

	// While steady is set neither side idles. stall_req asks the receiver for one long
	// hold-off; the receiver clears it once it has started holding.
	bit steady;
	bit stall_req;

	packet_buffer_drop_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	pbds_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.drops_seen   (drops_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Safety net: a healthy run finishes in a small fraction of this time.
	initial begin
		#1000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver side. It drops m_tready about a third of the time, except in steady
	// stretches, and once, on stall_req, holds it low for one long hold-off while the sender
	// keeps offering packets, so the result register fills and s_tready falls.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				m_tready <= 1'b0;
				repeat (200) @(negedge clk);
			end else if (steady) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99, 0) >= 34);
			end
		end
	end

	// Offers one packet beat and returns at the falling edge after it was taken. Gaps of
	// random length come first, so idle cycles land on every phase of the block's work.
	task automatic send_packet(input logic [31:0] arrival, input logic [31:0] service);
		while (!steady && $urandom_range(99, 0) < 34) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {service, arrival};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		packets_sent++;
	endtask

	// Stops offering and waits until every predicted result has come back. Each packet
	// always produces a result, so a few spare cycles are enough for the block to settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes buffer_size; only ever done once the block has gone quiet.
	task automatic set_size(input logic [SZ_W-1:0] sz);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= sz;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	initial begin
		logic [31:0]      base;
		logic [31:0]      arr;
		logic [31:0]      svc;
		logic [SZ_W-1:0]  sz;
		int               r;
		int               pmax;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		steady = 1'b0;
		stall_req = 1'b0;
		packets_sent = 0;
		settings_used = 0;
		base = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed start at the reset size of 64. An empty buffer starts a packet on
		// arrival, and a finish time equal to the arrival counts as finished.
		send_packet(32'd0, 32'd0);
		send_packet(32'd0, 32'd0);
		send_packet(32'd0, 32'd100);
		send_packet(32'd1, 32'd20);
		send_packet(32'd2, 32'd30);
		// An arrival earlier than the one before it is taken without complaint.
		send_packet(32'd1, 32'd5);
		send_packet(32'd120, 32'd0);
		send_packet(32'd155, 32'd10);

		// A buffer size of zero behaves like a size of one.
		set_size(7'd0);
		send_packet(32'd160, 32'd50);
		send_packet(32'd165, 32'd50);
		send_packet(32'd170, 32'd1);

		// Queue up several long packets, then shrink the buffer below what it holds:
		// new packets are dropped until enough of the held ones have finished.
		set_size(7'd64);
		for (int k = 0; k < 6; k++)
			send_packet(32'd200 + k, 32'd1000);
		set_size(7'd2);
		send_packet(32'd300, 32'd5);
		send_packet(32'd301, 32'd5);

		// The largest register value is clamped to the ring depth.
		set_size(7'd127);
		send_packet(32'd400, 32'd5);

		// Random phases, each under its own buffer size. Arrivals mostly creep forward by
		// less than the average service time so the buffer fills and drops happen; a few
		// jump ahead to drain it, and a few step backward. Each phase starts with a jump
		// large enough to empty the buffer. The last two phases run with high arrival
		// times so the upper bits of the field get exercised without early saturation.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: sz = 7'd64;
				1: sz = 7'd1;
				2: sz = 7'd0;
				3: sz = 7'd127;
				4: sz = 7'd3;
				5: sz = 7'd65;
				6: sz = SZ_W'($urandom_range(127, 0));
				default: sz = SZ_W'($urandom_range(8, 1));
			endcase
			set_size(sz);
			if (ph < 6)
				base = base + $urandom_range(90000, 10000);
			else if (ph == 6)
				base = $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
			else
				base = $urandom_range(32'hEFFF_FFFF, 32'hC000_0000);
			pmax = 20 + 10 * (ph % 4);
			steady = (ph == 3);
			for (int i = 0; i < 70; i++) begin
				r = $urandom_range(99, 0);
				if (r < 8)
					base = base + $urandom_range(600, 50);
				else
					base = base + $urandom_range(8, 0);
				arr = (r >= 96) ? base - $urandom_range(40, 0) : base;
				svc = $urandom_range(pmax, 0);
				if (r == 50)
					svc = $urandom_range(3000, 0);
				// Huge service times only near the end, since a saturated finish time
				// pins the buffer until an arrival reaches the top of the range.
				if (ph == 7 && r >= 90 && r < 96)
					svc = $urandom() & 32'h0FFF_FFFF;
				if (ph == 0 && i == 20)
					stall_req = 1'b1;
				// Once, the sender stops and waits for the block to empty its pipeline.
				if (ph == 2 && i == 35)
					drain();
				send_packet(arr, svc);
			end
			steady = 1'b0;
		end

		// Directed tail: finish times that saturate at the largest time, a start at the
		// largest time, and afterwards a packet arriving at zero stuck behind it.
		set_size(7'd64);
		send_packet(32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_packet(32'hFFFF_FFF1, 32'd3);
		send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		set_size(7'd1);
		send_packet(32'hFFFF_FFFF, 32'd0);
		send_packet(32'd0, 32'd0);

		drain();
		repeat (20) @(negedge clk);
		$display("Run covered %0d packets under %0d buffer settings: %0d results, %0d drops.",
			packets_sent, settings_used, results_seen, drops_seen);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/pbds_pkg.sv
rtl/core/pbds_cell.sv
rtl/core/packet_buffer_drop_scheduler.sv
tb/pbds_checker.sv
tb/testbench.sv
